>>> hw/rtl/bitplane_int4_grouped_dot_core_defines.svh
// Assertion macros for the grouped dot product core.
// Included by the modules that check their own logic; needs clk and rst_n in scope.
`ifndef BITPLANE_INT4_GROUPED_DOT_CORE_DEFINES_SVH
`define BITPLANE_INT4_GROUPED_DOT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BGD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("check failed: invariant");
`define BGD_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("check failed: same-cycle implication");
`define BGD_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("check failed: next-cycle implication");
`else
`define BGD_ASSERT_ALWAYS(label, prop)
`define BGD_ASSERT_IMP(label, cond, prop)
`define BGD_ASSERT_NXT(label, cond, prop)
`endif
`endif

>>> hw/rtl/bgd_pkg.sv
// Shared constants and controller/datapath interface types for the grouped dot core.
// No dependencies.
package bgd_pkg;

    localparam int MAX_GROUP_DEF = 256;
    localparam int ACC_WIDTH_DEF = 56;
    localparam int ACT_WIDTH_DEF = 16;

    localparam int GSIZE_W   = 9;
    localparam int TIER_W    = 2;
    localparam int SCALE_W   = 16;
    localparam int WEIGHT_W  = 5;
    localparam int DOT_W     = 56;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 9'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIER      = 2'd1;

    localparam logic [TIER_W-1:0] TIER_COARSE = 2'd0;
    localparam logic [TIER_W-1:0] TIER_MIDDLE = 2'd1;
    localparam logic [TIER_W-1:0] TIER_ALL    = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic scale;
        logic acc;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

endpackage

>>> hw/rtl/bgd_ctrl.sv
// Sequencer for the grouped dot core: accept, multiply, scale, accumulate.
// Depends on bgd_pkg and the assertion macro header.
`include "bitplane_int4_grouped_dot_core_defines.svh"

module bgd_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bgd_pkg::status_t status,
    output bgd_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MUL   = 2'd1;
    localparam logic [1:0] S_SCALE = 2'd2;
    localparam logic [1:0] S_ACC   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       acc_go;

    // hold the last element in the accumulate step while a finished sum still waits downstream
    assign acc_go   = !(status.last && status.out_busy);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.mul   = 1'b0;
        cmd.scale = 1'b0;
        cmd.acc   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (acc_go)
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `BGD_ASSERT_ALWAYS(a_cmd_onehot0, $onehot0({cmd.load, cmd.mul, cmd.scale, cmd.acc}))
    `BGD_ASSERT_NXT(a_load_then_mul, cmd.load, cmd.mul && !in_ready)
    `BGD_ASSERT_IMP(a_no_acc_when_blocked, status.last && status.out_busy, !cmd.acc)

endmodule

>>> hw/rtl/bgd_datapath.sv
// Datapath of the grouped dot core: config registers, weight rebuild, two multiplies,
// saturating accumulator and result register. Depends on bgd_pkg and the macro header.
`include "bitplane_int4_grouped_dot_core_defines.svh"

module bgd_datapath
#(
    parameter int MAX_GROUP = bgd_pkg::MAX_GROUP_DEF,
    parameter int ACC_WIDTH = bgd_pkg::ACC_WIDTH_DEF,
    parameter int ACT_WIDTH = bgd_pkg::ACT_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgd_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic signed [ACT_WIDTH-1:0]      activation,
    input  logic                             coarse_bit,
    input  logic                             middle_bit,
    input  logic [1:0]                       fine_code,
    input  logic signed [bgd_pkg::SCALE_W-1:0] group_scale,
    input  logic                             last,
    input  bgd_pkg::cmd_t                    cmd,
    output bgd_pkg::status_t                 status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [bgd_pkg::DOT_W-1:0] dot_sum,
    output logic                             saturated
);

    localparam int POS_W   = $clog2(MAX_GROUP);
    localparam int GS_W    = $clog2(MAX_GROUP + 1) > bgd_pkg::GSIZE_W ?
                             $clog2(MAX_GROUP + 1) : bgd_pkg::GSIZE_W;
    localparam int PROD_W  = ACT_WIDTH + bgd_pkg::WEIGHT_W;
    localparam int TERM_W  = PROD_W + bgd_pkg::SCALE_W;
    localparam int SUM_W   = (ACC_WIDTH > TERM_W ? ACC_WIDTH : TERM_W) + 1;
    localparam logic [GS_W-1:0] MAX_GS = GS_W'(MAX_GROUP);

    logic [bgd_pkg::GSIZE_W-1:0]        gsize_reg;
    logic [bgd_pkg::TIER_W-1:0]         tier_reg;
    logic [POS_W-1:0]                   pos_reg;
    logic signed [bgd_pkg::SCALE_W-1:0] scale_reg;
    logic signed [ACT_WIDTH-1:0]        act_reg;
    logic signed [bgd_pkg::WEIGHT_W-1:0] weight_reg;
    logic                               last_reg;
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [TERM_W-1:0]           term_reg;
    logic signed [ACC_WIDTH-1:0]        acc_reg;
    logic                               clip_reg;
    logic                               out_valid_reg;
    logic signed [bgd_pkg::DOT_W-1:0]   dot_reg;
    logic                               sat_reg;

    logic [GS_W-1:0]                    gs_wide;
    logic [GS_W-1:0]                    gs_eff;
    logic [GS_W-1:0]                    pos_inc;
    logic signed [bgd_pkg::WEIGHT_W-1:0] weight_next;
    logic signed [SUM_W-1:0]            sum;
    logic signed [SUM_W-1:0]            acc_max;
    logic signed [SUM_W-1:0]            acc_min;
    logic signed [ACC_WIDTH-1:0]        acc_next;
    logic                               clip_now;
    logic signed [63:0]                 acc_ext;

    // effective group size: zero acts as one, clamp at the largest group
    always_comb
    begin
        gs_wide = GS_W'(gsize_reg);
        if (gs_wide == '0)
            gs_eff = GS_W'(1);
        else if (gs_wide > MAX_GS)
            gs_eff = MAX_GS;
        else
            gs_eff = gs_wide;
        pos_inc = GS_W'(pos_reg) + GS_W'(1);
    end

    // rebuild the weight from its bit planes; tier three counts as all planes
    always_comb
    begin
        weight_next = coarse_bit ? 5'sd4 : -5'sd4;
        if (tier_reg >= bgd_pkg::TIER_MIDDLE)
            weight_next = weight_next + (middle_bit ? 5'sd2 : -5'sd2);
        if (tier_reg >= bgd_pkg::TIER_ALL)
            weight_next = weight_next + $signed({3'b000, fine_code}) - 5'sd1;
    end

    // exact sum, then clip to the accumulator range
    always_comb
    begin
        acc_max = $signed({{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}});
        acc_min = ~acc_max;
        sum     = SUM_W'(acc_reg) + SUM_W'(term_reg);
        clip_now = 1'b0;
        if (sum > acc_max)
        begin
            acc_next = ACC_WIDTH'(acc_max);
            clip_now = 1'b1;
        end
        else if (sum < acc_min)
        begin
            acc_next = ACC_WIDTH'(acc_min);
            clip_now = 1'b1;
        end
        else
        begin
            acc_next = ACC_WIDTH'(sum);
        end
        acc_ext = 64'(acc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg     <= bgd_pkg::GSIZE_RESET;
            tier_reg      <= bgd_pkg::TIER_ALL;
            pos_reg       <= '0;
            scale_reg     <= '0;
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == bgd_pkg::CFG_GROUP_LEN)
                gsize_reg <= cfg_data;
            if (cfg_valid && cfg_index == bgd_pkg::CFG_TIER)
                tier_reg <= cfg_data[bgd_pkg::TIER_W-1:0];
            if (cmd.load)
            begin
                if (pos_reg == '0)
                    scale_reg <= group_scale;
                if (last || pos_inc >= gs_eff)
                    pos_reg <= '0;
                else
                    pos_reg <= pos_inc[POS_W-1:0];
            end
            if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.acc)
            begin
                if (last_reg)
                begin
                    acc_reg       <= '0;
                    clip_reg      <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    acc_reg  <= acc_next;
                    clip_reg <= clip_reg | clip_now;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= activation;
            weight_reg <= weight_next;
            last_reg   <= last;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(act_reg) * PROD_W'(weight_reg);
        if (cmd.scale)
            term_reg <= TERM_W'(prod_reg) * TERM_W'(scale_reg);
        if (cmd.acc && last_reg)
        begin
            dot_reg <= acc_ext[bgd_pkg::DOT_W-1:0];
            sat_reg <= clip_reg | clip_now;
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign dot_sum         = dot_reg;
    assign saturated       = sat_reg;

    `BGD_ASSERT_IMP(a_no_result_overwrite, cmd.acc && last_reg, !out_valid_reg || out_ready)
    `BGD_ASSERT_NXT(a_result_posted, cmd.acc && last_reg, out_valid_reg && acc_reg == '0)
    `BGD_ASSERT_NXT(a_pos_clear_on_last, cmd.load && last, pos_reg == '0)

endmodule

>>> hw/rtl/bitplane_int4_grouped_dot_core.sv
// Top level of the grouped 4-bit weight dot product core.
// Depends on bgd_pkg, bgd_ctrl and bgd_datapath.
// Usage:
//   Input channel (in_valid/in_ready) carries one weight element per item:
//   activation, coarse_bit, middle_bit, fine_code, group_scale and last.
//   The scale is taken from the first element of each group (its length set
//   by config index 0); the element flagged last closes the dot product.
//   Output channel (out_valid/out_ready) carries dot_sum and saturated, one
//   item per dot product, produced by its last element.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
//   index 0 writes the group length, index 1 writes tier; other indexes are
//   ignored. Write it only while the core is idle.
// Sequence:
//   Each element steps through accept, activation times weight, times
//   scale, then the saturating add, so one element is in flight at a time.
//   The result is registered in the add step of the last element.
// Reset clears the accumulator, group position, held scale and clip flag
// and restores group length 32, tier 2. If the receiver stalls, the result
// is held in its output register and the next dot product still runs; only
// its own last element waits in the add step until the result is taken.
module bitplane_int4_grouped_dot_core
#(
    parameter int MAX_GROUP = bgd_pkg::MAX_GROUP_DEF,
    parameter int ACC_WIDTH = bgd_pkg::ACC_WIDTH_DEF,
    parameter int ACT_WIDTH = bgd_pkg::ACT_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bgd_pkg::CFG_DAT_W-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ACT_WIDTH-1:0]        activation,
    input  logic                               coarse_bit,
    input  logic                               middle_bit,
    input  logic [1:0]                         fine_code,
    input  logic signed [bgd_pkg::SCALE_W-1:0] group_scale,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [bgd_pkg::DOT_W-1:0]   dot_sum,
    output logic                               saturated
);

    bgd_pkg::cmd_t    cmd;
    bgd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bgd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bgd_datapath
    #(
        .MAX_GROUP (MAX_GROUP),
        .ACC_WIDTH (ACC_WIDTH),
        .ACT_WIDTH (ACT_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .activation  (activation),
        .coarse_bit  (coarse_bit),
        .middle_bit  (middle_bit),
        .fine_code   (fine_code),
        .group_scale (group_scale),
        .last        (last),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dot_sum     (dot_sum),
        .saturated   (saturated)
    );

endmodule
